// ----- hdl/ltr_pkg.sv -----
// Shared constants and types for the line-terminated receiver.
package ltr_pkg;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef logic [2:0] pstate_t;

  localparam pstate_t ST_NEW     = 3'd0;
  localparam pstate_t ST_TEXT    = 3'd1;
  localparam pstate_t ST_WAIT_LF = 3'd2;
  localparam pstate_t ST_ERR     = 3'd3;
  localparam pstate_t ST_ERR_LF  = 3'd4;

  // Per-byte decision of the parser.
  typedef struct packed {
    logic wr_en;
    logic emit;
  } parse_ctl_t;

endpackage

// ----- hdl/ltr_parser.sv -----
// Line parser: holds the framing state and fill count and decides store and emit actions.
module ltr_parser #(
  parameter int BUFFER_DEPTH = 64,
  parameter int AW = $clog2(BUFFER_DEPTH),
  parameter int CW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                end_mode,
  input  logic                byte_take,
  input  logic [7:0]          rx_byte,
  output ltr_pkg::parse_ctl_t ctl,
  output logic [AW-1:0]       wr_addr,
  output logic [CW-1:0]       emit_len
);

  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] LIMIT_C = CW'(BUFFER_DEPTH - 3);

  ltr_pkg::pstate_t state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    fill_inc;
  logic             is_cr, is_lf, term, emit;

  assign is_cr    = (rx_byte == ltr_pkg::CH_CR);
  assign is_lf    = (rx_byte == ltr_pkg::CH_LF);
  assign term     = is_cr || is_lf;
  assign fill_inc = fill_r + CW'(1);

  assign wr_addr   = fill_r[AW-1:0];
  assign ctl.wr_en = byte_take && (fill_r < DEPTH_C);
  assign ctl.emit  = byte_take && emit;
  assign emit_len  = (fill_inc > DEPTH_C) ? DEPTH_C : fill_inc;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_inc;
    emit      = 1'b0;
    if (end_mode) begin
      unique case (state_r)
        ltr_pkg::ST_NEW: begin
          if (term) begin
            fill_nxt = '0;
          end else begin
            state_nxt = ltr_pkg::ST_TEXT;
          end
        end
        ltr_pkg::ST_TEXT: begin
          if (term) begin
            emit      = 1'b1;
            state_nxt = ltr_pkg::ST_NEW;
            fill_nxt  = '0;
          end else if (fill_inc > LIMIT_C) begin
            state_nxt = ltr_pkg::ST_ERR;
            fill_nxt  = '0;
          end
        end
        default: begin
          // Every other code behaves as the error state in loose mode.
          state_nxt = term ? ltr_pkg::ST_NEW : ltr_pkg::ST_ERR;
          fill_nxt  = '0;
        end
      endcase
    end else begin
      unique case (state_r)
        ltr_pkg::ST_NEW: begin
          if (term) begin
            fill_nxt = '0;
          end else begin
            state_nxt = ltr_pkg::ST_TEXT;
          end
        end
        ltr_pkg::ST_TEXT: begin
          if (is_cr) begin
            state_nxt = ltr_pkg::ST_WAIT_LF;
          end else if (is_lf || (fill_inc > LIMIT_C)) begin
            state_nxt = ltr_pkg::ST_ERR;
            fill_nxt  = '0;
          end
        end
        ltr_pkg::ST_WAIT_LF: begin
          if (is_lf) begin
            emit      = 1'b1;
            state_nxt = ltr_pkg::ST_NEW;
          end else begin
            state_nxt = ltr_pkg::ST_ERR;
          end
          fill_nxt = '0;
        end
        ltr_pkg::ST_ERR_LF: begin
          state_nxt = is_lf ? ltr_pkg::ST_NEW : ltr_pkg::ST_ERR;
          fill_nxt  = '0;
        end
        default: begin
          // Error state and unused codes: a CR starts the recovery sequence.
          if (is_cr) begin
            state_nxt = ltr_pkg::ST_ERR_LF;
          end else begin
            state_nxt = ltr_pkg::ST_ERR;
            fill_nxt  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ltr_pkg::ST_NEW;
      fill_r  <= '0;
    end else if (byte_take) begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

// ----- hdl/line_terminated_receiver.sv -----
// Line-terminated byte receiver: line store memory, parser and line readout.
// Throughput: one byte per cycle is taken while no line is being read out.
// A completed line is read from the store one byte per cycle while the output is
// not stalled; the input is held off while it drains.
// A taken terminator sets the emitting flag; the first byte is then read into the output register.
// Reset clears the parser, the fill count, the mode and the output; the store is not cleared.
module line_terminated_receiver #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_end_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_line_last
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0] line_mem [BUFFER_DEPTH];

  logic                end_mode_r;
  logic                in_take;
  ltr_pkg::parse_ctl_t ctl;
  logic [AW-1:0]       wr_addr;
  logic [CW-1:0]       emit_len;

  logic                emitting_r;
  logic [CW-1:0]       rd_cnt_r;
  logic [CW-1:0]       emit_len_r;
  logic                out_valid_r;
  logic [7:0]          rd_data_r;
  logic                out_last_r;
  logic                issue;
  logic                rd_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !emitting_r;
  assign in_take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      end_mode_r <= cfg_end_mode;
    end
  end

  ltr_parser #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW),
    .CW           (CW)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .end_mode  (end_mode_r),
    .byte_take (in_take),
    .rx_byte   (in_rx_byte),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .emit_len  (emit_len)
  );

  // The read data register doubles as the output register.
  assign issue   = emitting_r && (!out_valid_r || out_ready);
  assign rd_last = (rd_cnt_r == (emit_len_r - CW'(1)));

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      line_mem[wr_addr] <= in_rx_byte;
    end
    if (issue) begin
      rd_data_r  <= line_mem[rd_cnt_r[AW-1:0]];
      out_last_r <= rd_last;
    end
    if (ctl.emit) begin
      emit_len_r <= emit_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitting_r  <= 1'b0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.emit) begin
        emitting_r <= 1'b1;
        rd_cnt_r   <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
        if (rd_last) begin
          emitting_r <= 1'b0;
        end
      end
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_line_byte = rd_data_r;
  assign out_line_last = out_last_r;

endmodule

// ----- verif/line_terminated_receiver_tb.sv -----
// Self-checking testbench for the CR/LF line framer: directed and random byte streams.
module line_terminated_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } line_byte_t;

  typedef enum {SH_ANY, SH_PLAIN, SH_LONGEST, SH_OVERLONG, SH_BROKEN, SH_NOISE} line_shape_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_end_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_line_byte;
  logic       out_line_last;

  line_terminated_receiver #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_end_mode (cfg_end_mode),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_line_byte(out_line_byte),
    .out_line_last(out_line_last)
  );

  // Framer state as the testbench sees it.
  logic             loose_end = 1'b0;
  ltr_pkg::pstate_t line_st = ltr_pkg::ST_NEW;
  logic [6:0]       line_fill = 7'd0;
  logic [7:0]       line_buf [DEPTH];

  logic [7:0] rx_feed [$];
  line_byte_t due_bytes [$];
  int         fed_count = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 9;
  int         recv_idle_pct = 59;
  logic       in_taken = 1'b0;
  logic       rx_hold = 1'b0;
  logic       hold_arm = 1'b0;

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic void queue_stored_line();
    int n;
    n = (line_fill > DEPTH) ? DEPTH : int'(line_fill);
    for (int k = 0; k < n; k++) due_bytes.push_back('{data: line_buf[k], last: (k == n - 1)});
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    logic             is_cr;
    logic             is_lf;
    logic             term;
    ltr_pkg::pstate_t st;
    is_cr = (b == ltr_pkg::CH_CR);
    is_lf = (b == ltr_pkg::CH_LF);
    term  = is_cr || is_lf;
    st    = line_st;
    if (line_fill < DEPTH) line_buf[line_fill[5:0]] = b;
    line_fill = line_fill + 7'd1;
    if (st == ltr_pkg::ST_NEW) begin
      if (term) line_fill = 7'd0;
      else st = ltr_pkg::ST_TEXT;
    end else if (st == ltr_pkg::ST_TEXT) begin
      if (loose_end && term) begin
        queue_stored_line();
        st = ltr_pkg::ST_NEW;
        line_fill = 7'd0;
      end else if (!loose_end && is_cr) begin
        st = ltr_pkg::ST_WAIT_LF;
      end else if (!loose_end && is_lf) begin
        st = ltr_pkg::ST_ERR;
        line_fill = 7'd0;
      end else if (line_fill > DEPTH - 3) begin
        // Over-long text: the line is dropped, a terminator would have won.
        st = ltr_pkg::ST_ERR;
        line_fill = 7'd0;
      end
    end else if (!loose_end && st == ltr_pkg::ST_WAIT_LF) begin
      if (is_lf) begin
        queue_stored_line();
        st = ltr_pkg::ST_NEW;
      end else begin
        st = ltr_pkg::ST_ERR;
      end
      line_fill = 7'd0;
    end else if (!loose_end && st == ltr_pkg::ST_ERR_LF) begin
      st = is_lf ? ltr_pkg::ST_NEW : ltr_pkg::ST_ERR;
      line_fill = 7'd0;
    end else if (!loose_end) begin
      if (is_cr) begin
        st = ltr_pkg::ST_ERR_LF;
      end else begin
        st = ltr_pkg::ST_ERR;
        line_fill = 7'd0;
      end
    end else begin
      // In loose mode every code above text behaves as the error state.
      st = term ? ltr_pkg::ST_NEW : ltr_pkg::ST_ERR;
      line_fill = 7'd0;
    end
    line_st = st;
  endfunction

  // Monitor: tracks configuration and accepted bytes, checks every line byte.
  always @(posedge clk) begin
    line_byte_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) loose_end = cfg_end_mode;
      if (in_valid && in_ready) frame_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (due_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected line byte %02h last %b",
                                  out_line_byte, out_line_last));
        end else begin
          want = due_bytes.pop_front();
          if (out_line_byte !== want.data)
            flag_mismatch($sformatf("line_byte %02h, expected %02h", out_line_byte, want.data));
          if (out_line_last !== want.last)
            flag_mismatch($sformatf("line_last %b, expected %b", out_line_last, want.last));
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Byte driver: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && rx_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off so that a finished line backs up into the input.
  initial begin
    wait (hold_arm);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  function automatic void feed(input logic [7:0] b);
    rx_feed.push_back(b);
    fed_count++;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ltr_pkg::CH_CR || b == ltr_pkg::CH_LF);
    return b;
  endfunction

  task automatic wait_drained();
    while (rx_feed.size() != 0 || in_valid || due_bytes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_end_mode(input logic mode);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_end_mode <= mode;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_line(input line_shape_t shape, input logic loose);
    int len;
    int roll;
    roll = $urandom_range(99);
    if (shape == SH_ANY)
      shape = (roll < 72) ? SH_PLAIN : (roll < 78) ? SH_OVERLONG :
              (roll < 90) ? SH_BROKEN : SH_NOISE;
    if (shape == SH_NOISE) begin
      repeat ($urandom_range(1, 6)) feed(8'($urandom_range(255)));
    end else begin
      if (shape == SH_LONGEST) len = DEPTH - 3;
      else if (shape == SH_OVERLONG) len = $urandom_range(DEPTH - 2, DEPTH + 2);
      else if ($urandom_range(11) == 0) len = $urandom_range(30, DEPTH - 3);
      else len = $urandom_range(1, 10);
      if ($urandom_range(4) == 0) feed($urandom_range(1) ? ltr_pkg::CH_CR : ltr_pkg::CH_LF);
      repeat (len) feed(text_byte());
      if (shape == SH_BROKEN) begin
        if ($urandom_range(1)) begin
          feed(ltr_pkg::CH_LF);
        end else begin
          feed(ltr_pkg::CH_CR);
          feed(text_byte());
        end
      end
      if (!loose) begin
        feed(ltr_pkg::CH_CR);
        feed(ltr_pkg::CH_LF);
      end else begin
        case ($urandom_range(2))
          0: feed(ltr_pkg::CH_CR);
          1: feed(ltr_pkg::CH_LF);
          default: begin
            feed(ltr_pkg::CH_CR);
            feed(ltr_pkg::CH_LF);
          end
        endcase
      end
    end
  endtask

  task automatic random_phase(input logic loose, input int target, input line_shape_t first);
    int start;
    start = fed_count;
    set_end_mode(loose);
    queue_line(first, loose);
    while (fed_count - start < target) queue_line(SH_ANY, loose);
    wait_drained();
  endtask

  initial begin
    // Strict mode: leading terminators, extremes and zero as text, stray LF,
    // CR then other bytes in and out of the error state; ends halfway through
    // a CR/LF pair so the mode change lands mid-line.
    logic [7:0] strict_seq [20];
    logic [7:0] loose_seq [7];

    strict_seq = '{
      ltr_pkg::CH_CR, ltr_pkg::CH_LF, 8'h00, 8'hff, ltr_pkg::CH_CR, ltr_pkg::CH_LF,
      8'h42, ltr_pkg::CH_LF, 8'h43, ltr_pkg::CH_CR, 8'h44, ltr_pkg::CH_CR, ltr_pkg::CH_LF,
      8'h45, ltr_pkg::CH_CR, 8'h46, ltr_pkg::CH_CR, ltr_pkg::CH_LF,
      8'h47, ltr_pkg::CH_CR};
    loose_seq = '{8'h48, ltr_pkg::CH_LF, 8'h49, ltr_pkg::CH_CR, ltr_pkg::CH_LF,
                  8'h4b, ltr_pkg::CH_LF};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_end_mode(1'b0);
    foreach (strict_seq[i]) feed(strict_seq[i]);
    wait_drained();
    set_end_mode(1'b1);
    foreach (loose_seq[i]) feed(loose_seq[i]);
    wait_drained();

    random_phase(1'b0, 60, SH_LONGEST);

    send_idle_pct = 59;
    recv_idle_pct = 9;
    random_phase(1'b1, 60, SH_OVERLONG);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_arm = 1'b1;
    random_phase(1'b0, 30, SH_PLAIN);
    random_phase(1'b1, 30, SH_PLAIN);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ltr_pkg.sv
hdl/ltr_parser.sv
hdl/line_terminated_receiver.sv
verif/line_terminated_receiver_tb.sv
